FILE: rtl/core/pvhl_pkg.sv
// ----------------------------------------------------------------------------
// pvhl_pkg
// Shared widths, register indexes and the stage type of the pivot detector.
// ----------------------------------------------------------------------------
package pvhl_pkg;

  // fixed field widths of the bar, result and register-write beats
  localparam int PRICE_W     = 32;
  localparam int INDEX_W     = 32;
  localparam int SPAN_W      = 5;
  localparam int CFG_INDEX_W = 8;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_SPAN  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_SPAN = 8'd1;

  // span values after reset
  localparam logic [SPAN_W-1:0] SPAN_RESET = 5'd5;

  // bar parked between the window update and the compare
  typedef struct packed {
    logic               valid;
    logic               emit;
    logic [INDEX_W-1:0] index;
  } stage_t;

endpackage

FILE: rtl/core/pvhl_if.sv
// ----------------------------------------------------------------------------
// pvhl_if
// Valid/ready channels of the pivot detector: bars, results, register writes.
// ----------------------------------------------------------------------------
interface pvhl_bar_if
  import pvhl_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] high_price;
  logic [PRICE_W-1:0] low_price;
  logic               series_start;

  modport source (output valid, high_price, low_price, series_start, input ready);
  modport sink   (input valid, high_price, low_price, series_start, output ready);
endinterface

interface pvhl_result_if
  import pvhl_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] center_index;
  logic               is_pivot_high;
  logic [PRICE_W-1:0] pivot_high_value;
  logic               is_pivot_low;
  logic [PRICE_W-1:0] pivot_low_value;

  modport source (output valid, center_index, is_pivot_high, pivot_high_value,
                  is_pivot_low, pivot_low_value, input ready);
  modport sink   (input valid, center_index, is_pivot_high, pivot_high_value,
                  is_pivot_low, pivot_low_value, output ready);
endinterface

interface pvhl_cfg_if
  import pvhl_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [SPAN_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/pvhl_window.sv
// ----------------------------------------------------------------------------
// pvhl_window
// Bar intake: shifts the high/low windows, tracks fill and bar index, and
// parks the accepted bar for the compare stage.
// ----------------------------------------------------------------------------
module pvhl_window
  import pvhl_pkg::*;
#(
  parameter int DEPTH   = 33,
  parameter int STORE_W = 32,
  parameter int NEED_W  = 6
) (
  input  logic               clk,
  input  logic               rst,
  pvhl_bar_if.sink           bar,
  input  logic [NEED_W-1:0]  need,
  input  logic               take,
  output stage_t             stage,
  output logic [STORE_W-1:0] win_high [DEPTH],
  output logic [STORE_W-1:0] win_low  [DEPTH]
);

  logic               accept;
  logic [NEED_W-1:0]  fill;
  logic [NEED_W-1:0]  fill_base;
  logic [NEED_W-1:0]  fill_next;
  logic [INDEX_W-1:0] bar_counter;
  logic [INDEX_W-1:0] index_base;

  // stage frees up when its bar moves on to the result register
  assign bar.ready = !stage.valid || take;
  assign accept    = bar.valid && bar.ready;

  // series start restarts fill and index before this bar
  always_comb begin
    fill_base  = bar.series_start ? '0 : fill;
    index_base = bar.series_start ? '0 : bar_counter;
    fill_next  = (fill_base < NEED_W'(DEPTH)) ? fill_base + NEED_W'(1) : fill_base;
  end

  // fill, index and stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      bar_counter <= '0;
      stage.valid <= 1'b0;
    end else if (accept) begin
      fill        <= fill_next;
      bar_counter <= index_base + INDEX_W'(1);
      stage.valid <= 1'b1;
      stage.emit  <= (fill_next >= need);
      stage.index <= index_base;
    end else if (take) begin
      stage.valid <= 1'b0;
    end
  end

  // window shift line, newest bar at entry 0
  always_ff @(posedge clk) begin
    if (accept) begin
      win_high[0] <= STORE_W'(bar.high_price);
      win_low[0]  <= STORE_W'(bar.low_price);
      for (int k = 1; k < DEPTH; k++) begin
        win_high[k] <= win_high[k-1];
        win_low[k]  <= win_low[k-1];
      end
    end
  end

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> stage.valid)
    else $error("accepted bar not parked in stage");

  a_series_start_index: assert property (@(posedge clk) disable iff (rst)
    accept && bar.series_start |=> stage.index == '0)
    else $error("series start did not restart the bar index");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage.valid && !take |=> stage.valid && $stable(stage.index))
    else $error("stalled stage lost its bar");

endmodule

FILE: rtl/core/pvhl_compare.sv
// ----------------------------------------------------------------------------
// pvhl_compare
// Picks the center bar, compares it against the window and loads the result
// register.
// ----------------------------------------------------------------------------
module pvhl_compare
  import pvhl_pkg::*;
#(
  parameter int DEPTH     = 33,
  parameter int STORE_W   = 32,
  parameter int NEED_W    = 6,
  parameter int MAX_RIGHT = 16,
  parameter int RSPAN_W   = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  stage_t             stage,
  input  logic [STORE_W-1:0] win_high [DEPTH],
  input  logic [STORE_W-1:0] win_low  [DEPTH],
  input  logic [NEED_W-1:0]  need,
  input  logic [RSPAN_W-1:0] rspan,
  output logic               take,
  pvhl_result_if.source      result
);

  logic [STORE_W-1:0] center_high;
  logic [STORE_W-1:0] center_low;
  logic               ph;
  logic               pl;

  // stage moves on whenever the result register is free or being drained
  assign take = stage.valid && (!result.valid || result.ready);

  // center bar select
  always_comb begin
    center_high = win_high[0];
    center_low  = win_low[0];
    for (int k = 1; k <= MAX_RIGHT; k++) begin
      if (int'(rspan) == k) begin
        center_high = win_high[k];
        center_low  = win_low[k];
      end
    end
  end

  // strict compare against every other bar in the window
  always_comb begin
    ph = 1'b1;
    pl = 1'b1;
    for (int k = 0; k < DEPTH; k++) begin
      if ((k < int'(need)) && (k != int'(rspan))) begin
        if (win_high[k] >= center_high) ph = 1'b0;
        if (win_low[k]  <= center_low)  pl = 1'b0;
      end
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= stage.emit;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take && stage.emit) begin
      result.center_index     <= stage.index - INDEX_W'(rspan);
      result.is_pivot_high    <= ph;
      result.pivot_high_value <= PRICE_W'(center_high);
      result.is_pivot_low     <= pl;
      result.pivot_low_value  <= PRICE_W'(center_low);
    end
  end

  a_emit_loads_result: assert property (@(posedge clk) disable iff (rst)
    take && stage.emit |=> result.valid)
    else $error("emitting bar did not load the result register");

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid survived reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.center_index))
    else $error("stalled result beat changed");

endmodule

FILE: rtl/core/windowed_pivot_high_low_detector_top.sv
// ----------------------------------------------------------------------------
// windowed_pivot_high_low_detector_top
// Pivot high / pivot low detector over a sliding window of price bars.
// ----------------------------------------------------------------------------
// Usage:
//   bar    : one beat per price bar (high, low, series_start). series_start
//            restarts the window fill and the bar index with this bar.
//   result : one beat per bar once the window of left+right+1 bars is full,
//            reporting the bar right_span positions back; no beat before.
//   cfg    : register writes, index 0 left_span, 1 right_span, always ready.
//            Write only while no bar is in flight; spans clamp to the maximum.
// Path: a bar is parked in the stage register, then in the result register.
// Throughput: one bar per cycle while results drain; the bar is shifted into
//   the window in the accept cycle, then one parallel comparator bank over
//   the whole window feeds the result register once the stage is taken.
// Reset: window fill, bar index and all valids clear; spans return to 5.
// Stall: a held result keeps its beat; one more bar parks in the compare
//   stage, then bar.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module windowed_pivot_high_low_detector_top
  import pvhl_pkg::*;
#(
  parameter int MAX_LEFT   = 16,
  parameter int MAX_RIGHT  = 16,
  parameter int PRICE_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  pvhl_bar_if.sink      bar,
  pvhl_cfg_if.sink      cfg,
  pvhl_result_if.source result
);

  localparam int DEPTH   = MAX_LEFT + MAX_RIGHT + 1;
  localparam int STORE_W = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
  localparam int NEED_W  = $clog2(DEPTH + 1);
  localparam int LSPAN_W = $clog2(MAX_LEFT + 1);
  localparam int RSPAN_W = $clog2(MAX_RIGHT + 1);

  logic [SPAN_W-1:0]  left_span;
  logic [SPAN_W-1:0]  right_span;
  logic [LSPAN_W-1:0] lspan;
  logic [RSPAN_W-1:0] rspan;
  logic [NEED_W-1:0]  need;
  logic               take;
  stage_t             stage;
  logic [STORE_W-1:0] win_high [DEPTH];
  logic [STORE_W-1:0] win_low  [DEPTH];

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_span  <= SPAN_RESET;
      right_span <= SPAN_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LEFT_SPAN:  left_span  <= cfg.data;
        REG_RIGHT_SPAN: right_span <= cfg.data;
        default: ;
      endcase
    end
  end

  // clamped spans and window length
  always_comb begin
    lspan = (int'(left_span) > MAX_LEFT) ? LSPAN_W'(MAX_LEFT) : LSPAN_W'(left_span);
    rspan = (int'(right_span) > MAX_RIGHT) ? RSPAN_W'(MAX_RIGHT) : RSPAN_W'(right_span);
    need  = NEED_W'(lspan) + NEED_W'(rspan) + NEED_W'(1);
  end

  pvhl_window #(
    .DEPTH   (DEPTH),
    .STORE_W (STORE_W),
    .NEED_W  (NEED_W)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .bar      (bar),
    .need     (need),
    .take     (take),
    .stage    (stage),
    .win_high (win_high),
    .win_low  (win_low)
  );

  pvhl_compare #(
    .DEPTH     (DEPTH),
    .STORE_W   (STORE_W),
    .NEED_W    (NEED_W),
    .MAX_RIGHT (MAX_RIGHT),
    .RSPAN_W   (RSPAN_W)
  ) u_compare (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .win_high (win_high),
    .win_low  (win_low),
    .need     (need),
    .rspan    (rspan),
    .take     (take),
    .result   (result)
  );

endmodule
